// ===== src/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the maximum-sum path block: item and result
// payloads, store geometry and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  localparam int DEPTH   = 4096;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 45;

  typedef struct packed {
    logic                       mode;
    logic                       has_value;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] path_sum;
    logic                    overflow;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // accept the item on the input channel
    logic rd;     // issue store reads, fold a closed segment into the total
    logic ex;     // take one walk step on the read data
    logic fin;    // fold the last segment, load the result, clear the pair
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pair_done;  // the offered item closes the second sequence
    logic walk_end;   // both pointers have run past their counts
    logic out_busy;   // a result is still waiting to be taken
  } status_t;

endpackage

`default_nettype wire

// ===== src/max_sum_path_two_sorted_lists.sv =====
// ----------------------------------------------------------------------------
// max_sum_path_two_sorted_lists
// Maximum-sum path through two ascending sequences loaded item by item.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on item_valid/item_ready/item. mode picks the sequence,
//   has_value appends value, last closes the sequence. Items for a sequence
//   already closed are taken and ignored; elements past the store depth are
//   dropped and raise the overflow flag of the pair.
//   While loading, item_ready stays high, so every item offered is taken. The item that closes the
//   second sequence starts the walk, during which item_ready stays low.
//   Each walk step is a store read, then a compare and add, with
//   max(n1,n2) to n1+n2 steps; the step is split so because each store
//   has a single read port with registered read data. The total then goes
//   to the output once the previous result has left.
//   One result per pair leaves on result_valid/result_ready/result. It sits
//   in an output register, so loading of the next pair goes on while it
//   waits; a new result is held back until the previous one is taken.
//   Reset clears counts, close flags and the output; store contents are
//   not cleared, and read data is used only from addresses already written.
// ----------------------------------------------------------------------------
`default_nettype none

module max_sum_path_two_sorted_lists (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire msp_pkg::in_t  item,
  output logic               result_valid,
  input  wire logic          result_ready,
  output msp_pkg::out_t      result
);

  msp_pkg::cmd_t    cmd;
  msp_pkg::status_t status;

  msp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  msp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // the closing item starts the walk: no further item until it is done
  a_walk_blocks_input: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && status.pair_done |=> !item_ready)
    else $error("item taken right after the pair closed");

  // a finished total never overwrites a result still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !(result_valid && !result_ready))
    else $error("result overwritten while stalled");

  a_fin_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> result_valid)
    else $error("finished walk produced no result");

  // input is only taken while loading, never during the walk
  a_load_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> item_ready && !cmd.rd && !cmd.ex && !cmd.fin)
    else $error("load command outside the load phase");

endmodule

`default_nettype wire

// ===== src/msp_store.sv =====
// ----------------------------------------------------------------------------
// msp_store
// Element store for one sequence: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_store (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [msp_pkg::ADDR_W-1:0]        wr_addr,
  input  wire logic [msp_pkg::VALUE_W-1:0]       wr_data,
  input  wire logic [msp_pkg::ADDR_W-1:0]        rd_addr,
  output logic      [msp_pkg::VALUE_W-1:0]       rd_data
);

  logic [msp_pkg::VALUE_W-1:0] mem [msp_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/msp_ctrl.sv =====
// ----------------------------------------------------------------------------
// msp_ctrl
// Controller: loads items until both sequences close, then steps the
// two-pointer walk (read, execute) until both sides run out, and hands the
// total to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire msp_pkg::status_t status,
  output msp_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EX   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
        if (item_valid && status.pair_done) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_EX;
      end
      ST_EX: begin
        if (status.walk_end) begin
          state_next = ST_FIN;
        end else begin
          cmd.ex     = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_FIN: begin
        // hold until the previous result has left
        if (!status.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/msp_dp.sv =====
// ----------------------------------------------------------------------------
// msp_dp
// Datapath: the two element stores, counts and close flags, walk pointers,
// running segment sums, the total and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire msp_pkg::cmd_t    cmd,
  input  wire msp_pkg::in_t     item,
  output msp_pkg::status_t      status,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output msp_pkg::out_t         result
);

  logic [msp_pkg::CNT_W-1:0]   first_count;
  logic [msp_pkg::CNT_W-1:0]   second_count;
  logic                        first_closed;
  logic                        second_closed;
  logic                        overflow_seen;
  logic [msp_pkg::CNT_W-1:0]   i_ptr;
  logic [msp_pkg::CNT_W-1:0]   j_ptr;
  logic signed [msp_pkg::SUM_W-1:0] s1;
  logic signed [msp_pkg::SUM_W-1:0] s2;
  logic signed [msp_pkg::SUM_W-1:0] total;
  logic                        pend;

  logic [msp_pkg::VALUE_W-1:0] rd_a;
  logic [msp_pkg::VALUE_W-1:0] rd_b;

  logic                        sel_closed;
  logic                        oth_closed;
  logic [msp_pkg::CNT_W-1:0]   sel_count;
  logic                        has_room;
  logic                        wr_first;
  logic                        wr_second;
  logic                        a_left;
  logic                        b_left;
  logic signed [msp_pkg::VALUE_W-1:0] a_val;
  logic signed [msp_pkg::VALUE_W-1:0] b_val;
  logic signed [msp_pkg::SUM_W-1:0]   a_ext;
  logic signed [msp_pkg::SUM_W-1:0]   b_ext;
  logic signed [msp_pkg::SUM_W-1:0]   seg_max;

  assign sel_closed = item.mode ? second_closed : first_closed;
  assign oth_closed = item.mode ? first_closed  : second_closed;
  assign sel_count  = item.mode ? second_count  : first_count;
  assign has_room   = sel_count < msp_pkg::CNT_W'(msp_pkg::DEPTH);

  assign wr_first  = cmd.load && !sel_closed && item.has_value && has_room && !item.mode;
  assign wr_second = cmd.load && !sel_closed && item.has_value && has_room && item.mode;

  assign a_left = i_ptr < first_count;
  assign b_left = j_ptr < second_count;

  assign a_val   = $signed(rd_a);
  assign b_val   = $signed(rd_b);
  assign a_ext   = msp_pkg::SUM_W'(a_val);
  assign b_ext   = msp_pkg::SUM_W'(b_val);
  assign seg_max = (s1 > s2) ? s1 : s2;

  assign status.pair_done = !sel_closed && item.last && oth_closed;
  assign status.walk_end  = !a_left && !b_left;
  assign status.out_busy  = result_valid && !result_ready;

  msp_store u_first (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (first_count[msp_pkg::ADDR_W-1:0]),
    .wr_data (item.value),
    .rd_addr (i_ptr[msp_pkg::ADDR_W-1:0]),
    .rd_data (rd_a)
  );

  msp_store u_second (
    .clk     (clk),
    .wr_en   (wr_second),
    .wr_addr (second_count[msp_pkg::ADDR_W-1:0]),
    .wr_data (item.value),
    .rd_addr (j_ptr[msp_pkg::ADDR_W-1:0]),
    .rd_data (rd_b)
  );

  // load side: counts, close flags, overflow
  always_ff @(posedge clk) begin
    if (rst || cmd.fin) begin
      first_count   <= '0;
      second_count  <= '0;
      first_closed  <= 1'b0;
      second_closed <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (cmd.load && !sel_closed) begin
      if (wr_first) begin
        first_count <= first_count + 1'b1;
      end
      if (wr_second) begin
        second_count <= second_count + 1'b1;
      end
      if (item.has_value && !has_room) begin
        overflow_seen <= 1'b1;
      end
      if (item.last) begin
        if (item.mode) begin
          second_closed <= 1'b1;
        end else begin
          first_closed <= 1'b1;
        end
      end
    end
  end

  // walk: one step per read/execute pair
  always_ff @(posedge clk) begin
    if (rst || cmd.fin) begin
      i_ptr <= '0;
      j_ptr <= '0;
      s1    <= '0;
      s2    <= '0;
      total <= '0;
      pend  <= 1'b0;
    end else if (cmd.rd) begin
      // fold the segment closed by the last common value
      if (pend) begin
        total <= total + seg_max;
        s1    <= '0;
        s2    <= '0;
        pend  <= 1'b0;
      end
    end else if (cmd.ex) begin
      if (a_left && b_left) begin
        if (a_val == b_val) begin
          s1    <= s1 + a_ext;
          s2    <= s2 + b_ext;
          i_ptr <= i_ptr + 1'b1;
          j_ptr <= j_ptr + 1'b1;
          pend  <= 1'b1;
        end else if (a_val > b_val) begin
          s2    <= s2 + b_ext;
          j_ptr <= j_ptr + 1'b1;
        end else begin
          s1    <= s1 + a_ext;
          i_ptr <= i_ptr + 1'b1;
        end
      end else if (b_left) begin
        s2    <= s2 + b_ext;
        j_ptr <= j_ptr + 1'b1;
      end else begin
        s1    <= s1 + a_ext;
        i_ptr <= i_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.fin) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result.path_sum <= total + seg_max;
      result.overflow <= overflow_seen;
    end
  end

endmodule

`default_nettype wire
